### rtl/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

   localparam int WordWidth     = 32;
   localparam int NumDigits     = 10;
   localparam int DigitIdxWidth = $clog2(NumDigits);
   localparam int StepWidth     = $clog2(WordWidth);
   localparam int QueueDepth    = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharMinus = 8'h2D;

   typedef struct packed {
      logic                 action;
      logic [WordWidth-1:0] value;
   } b2da_req_type;

   typedef struct packed {
      logic [7:0] ascii_char;
      logic       last;
   } b2da_rsp_type;

   // Classified job: sign flag and magnitude to convert.
   typedef struct packed {
      logic                 neg;
      logic [WordWidth-1:0] mag;
   } b2da_job_type;

endpackage

### rtl/b2da_front.sv
// Front end: accepts input items, forms sign flag and magnitude.
module b2da_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  b2da_pkg::b2da_req_type req_item,
   output logic                  job_valid,
   output b2da_pkg::b2da_job_type job_item,
   input  logic                  job_full
);
   import b2da_pkg::*;

   logic         job_valid_ff;
   logic         job_valid_in;
   b2da_job_type job_ff;
   b2da_job_type job_in;
   logic         accept;
   logic         push;

   assign push      = job_valid_ff && !job_full;
   assign req_stall = job_valid_ff && job_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      job_in.neg = req_item.action && req_item.value[WordWidth-1];
      // two's complement negate; the most negative value maps onto itself as unsigned
      job_in.mag = job_in.neg ? (~req_item.value + WordWidth'(1)) : req_item.value;
      job_valid_in = accept || (job_valid_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = job_valid_ff;
   assign job_item  = job_ff;

endmodule

### rtl/b2da_queue.sv
// Short job queue between the front end and the conversion back end.
module b2da_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b2da_pkg::b2da_job_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output b2da_pkg::b2da_job_type head_item
);
   import b2da_pkg::*;

   b2da_job_type             entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff;
   logic [QueuePtrWidth-1:0] rd_ptr_ff;
   logic [QueueCntWidth-1:0] count_ff;
   logic                     do_push;
   logic                     do_pop;

   assign full      = (count_ff == QueueCntWidth'(QueueDepth));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_item = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0
                                                                         : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0
                                                                         : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/b2da_back.sv
// Back end: iterative double-dabble conversion and character emission.
module b2da_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  b2da_pkg::b2da_job_type job_item,
   output logic                  job_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output b2da_pkg::b2da_rsp_type rsp_item
);
   import b2da_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_FIND,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   state_type                       state_ff;
   logic [WordWidth-1:0]            bin_ff;
   logic [NumDigits-1:0][3:0]       bcd_ff;
   logic [StepWidth-1:0]            step_ff;
   logic                            neg_ff;
   logic [DigitIdxWidth-1:0]        idx_ff;
   logic                            rsp_valid_ff;
   b2da_rsp_type                    rsp_ff;

   logic [NumDigits-1:0][3:0]       bcd_adj;
   logic [NumDigits*4-1:0]          bcd_adj_flat;
   logic [NumDigits-1:0][3:0]       bcd_in;
   logic [WordWidth-1:0]            bin_in;
   logic [DigitIdxWidth-1:0]        top_idx;
   logic                            emit_ok;
   logic                            emit_now;

   assign emit_ok  = !rsp_valid_ff || !rsp_stall;
   assign emit_now = emit_ok && (state_ff == ST_SIGN || state_ff == ST_DIGITS);
   assign job_pop  = (state_ff == ST_IDLE) && job_valid;

   // one double-dabble step: add 3 to digits of 5 or more, then shift in the next bit
   always_comb begin
      for (int i = 0; i < NumDigits; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? (bcd_ff[i] + 4'd3) : bcd_ff[i];
      end
      bcd_adj_flat = bcd_adj;
      bcd_in       = {bcd_adj_flat[NumDigits*4-2:0], bin_ff[WordWidth-1]};
      bin_in       = {bin_ff[WordWidth-2:0], 1'b0};
   end

   // most significant nonzero digit; zero prints one digit
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < NumDigits; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            top_idx = DigitIdxWidth'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_now) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  bin_ff   <= job_item.mag;
                  bcd_ff   <= '0;
                  step_ff  <= '0;
                  neg_ff   <= job_item.neg;
                  state_ff <= ST_CONVERT;
               end
            end
            ST_CONVERT: begin
               bcd_ff  <= bcd_in;
               bin_ff  <= bin_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == StepWidth'(WordWidth - 1)) begin
                  state_ff <= ST_FIND;
               end
            end
            ST_FIND: begin
               idx_ff   <= top_idx;
               state_ff <= neg_ff ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
               if (emit_ok) begin
                  rsp_ff.ascii_char <= CharMinus;
                  rsp_ff.last       <= 1'b0;
                  state_ff          <= ST_DIGITS;
               end
            end
            ST_DIGITS: begin
               if (emit_ok) begin
                  rsp_ff.ascii_char <= CharZero + {4'd0, bcd_ff[idx_ff]};
                  rsp_ff.last       <= (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff <= idx_ff - 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### rtl/binary_to_decimal_ascii_core.sv
// Each accepted item is registered in the front end and passed through the queue to the
// back end, which converts it in a 32-step shift-and-add-3 loop, finds the leading
// digit and emits the characters (1 to 11 per item), a minus sign first when the value
// is negative, each held while the result side stalls; the front end and a two-entry
// queue take new items while the back end works.
// Reset: synchronous, clears queue, handshake and sequencer state; no clearing pass.
module binary_to_decimal_ascii_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  b2da_pkg::b2da_req_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output b2da_pkg::b2da_rsp_type rsp_item
);
   import b2da_pkg::*;

   logic         front_valid;
   b2da_job_type front_job;
   logic         queue_full;
   logic         queue_not_empty;
   b2da_job_type queue_head;
   logic         back_pop;

   b2da_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .job_valid (front_valid),
      .job_item  (front_job),
      .job_full  (queue_full)
   );

   b2da_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_job),
      .full      (queue_full),
      .pop       (back_pop),
      .not_empty (queue_not_empty),
      .head_item (queue_head)
   );

   b2da_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_not_empty),
      .job_item  (queue_head),
      .job_pop   (back_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

### rtl/b2da_checker.sv
// Port-level checks for the binary to decimal ASCII converter, bound to the top level.
module b2da_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input b2da_pkg::b2da_rsp_type rsp_item
);
   import b2da_pkg::*;

   logic rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)))
      else $error("stalled result changed");

   // characters of one number follow without gaps
   assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_item.last) |=> rsp_valid)
      else $error("gap inside a number");

   // a sign is followed by a nonzero leading digit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_item.ascii_char == CharMinus) |=>
         (rsp_item.ascii_char != CharMinus && rsp_item.ascii_char != CharZero))
      else $error("bad character after sign");

endmodule

bind binary_to_decimal_ascii_core b2da_checker u_b2da_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

### tb/sv/decimal_text_monitor.sv
// Watches the converter's channels, predicts the decimal text and compares each character.
`timescale 1ns / 1ps

module decimal_text_monitor (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  b2da_pkg::b2da_req_type req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  b2da_pkg::b2da_rsp_type rsp_item,
   output int                     errors,
   output int                     pending
);
   import b2da_pkg::*;

   b2da_rsp_type text_queue[$];

   initial begin
      errors  = 0;
      pending = 0;
   end

   // Appends the characters one input item should produce.
   function automatic void queue_decimal_text(input b2da_req_type req);
      logic [WordWidth-1:0] magnitude;
      logic [3:0]           digit_buf[NumDigits];
      int                   count;
      b2da_rsp_type         ch;
      magnitude = req.value;
      count     = 0;
      if (req.action && req.value[WordWidth-1]) begin
         ch.ascii_char = CharMinus;
         ch.last       = 1'b0;
         text_queue.push_back(ch);
         // unsigned negate, so the most negative value stays exact
         magnitude = ~req.value + 1'b1;
      end
      do begin
         digit_buf[count] = 4'(magnitude % 10);
         magnitude        = magnitude / 10;
         count++;
      end while (magnitude != 0);
      for (int k = count - 1; k >= 0; k--) begin
         ch.ascii_char = CharZero + 8'(digit_buf[k]);
         ch.last       = (k == 0);
         text_queue.push_back(ch);
      end
   endfunction

   always @(posedge clock) begin
      b2da_rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            queue_decimal_text(req_item);
         end
         if (rsp_valid && !rsp_stall) begin
            if (text_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected item, expected none, actual char %h last %b",
                        $time, rsp_item.ascii_char, rsp_item.last);
            end else begin
               want = text_queue.pop_front();
               if (rsp_item.ascii_char !== want.ascii_char) begin
                  errors++;
                  $display("%0t: ascii_char mismatch, expected %h actual %h",
                           $time, want.ascii_char, rsp_item.ascii_char);
               end
               if (rsp_item.last !== want.last) begin
                  errors++;
                  $display("%0t: last mismatch, expected %b actual %b",
                           $time, want.last, rsp_item.last);
               end
            end
         end
      end
      pending = text_queue.size();
   end

endmodule

### tb/sv/testbench.sv
// Top of the converter testbench: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module testbench;
   import b2da_pkg::*;

   localparam int RandomItems = 392;
   localparam int CalmItems   = 60;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   b2da_req_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   b2da_rsp_type rsp_item;
   logic         calm      = 1'b0;
   int           errors;
   int           pending;

   logic [WordWidth-1:0] pow10[NumDigits];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   binary_to_decimal_ascii_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   decimal_text_monitor monitor (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .errors    (errors),
      .pending   (pending)
   );

   // Called at a rising edge; returns at the edge where the item is taken.
   task automatic send_word(input logic action, input logic [WordWidth-1:0] value);
      b2da_req_type it;
      it.action = action;
      it.value  = value;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic [WordWidth-1:0] pick_value();
      logic [WordWidth-1:0] v;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = $urandom >> $urandom_range(0, 31);
         2: v = pow10[$urandom_range(0, NumDigits - 1)] + $urandom_range(0, 2) - 1;
         3: v = 32'h7FFF_FFFE + $urandom_range(0, 3);
         4: v = $urandom_range(0, 20);
         default: v = 32'(0) - $urandom_range(1, 20);
      endcase
      return v;
   endfunction

   // Result side: stall bursts mixed with free stretches until the calm tail.
   initial begin
      wait (!reset);
      while (!calm) begin
         @(posedge clock);
         if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   initial begin
      pow10[0] = 1;
      for (int k = 1; k < NumDigits; k++) pow10[k] = pow10[k-1] * 10;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // zero, extremes, sign boundaries, digit-count boundaries
      send_word(1'b0, 32'h0000_0000);
      send_word(1'b1, 32'h0000_0000);
      send_word(1'b0, 32'hFFFF_FFFF);
      send_word(1'b1, 32'hFFFF_FFFF);
      send_word(1'b0, 32'h8000_0000);
      send_word(1'b1, 32'h8000_0000);
      send_word(1'b0, 32'h7FFF_FFFF);
      send_word(1'b1, 32'h7FFF_FFFF);
      send_word(1'b0, 32'h8000_0001);
      send_word(1'b1, 32'h8000_0001);
      send_word(1'b1, 32'd1);
      send_word(1'b0, 32'd9);
      send_word(1'b1, 32'd10);
      send_word(1'b0, 32'd99);
      send_word(1'b1, 32'd100);
      send_word(1'b0, 32'd999999999);
      send_word(1'b1, 32'd1000000000);
      send_word(1'b0, 32'd4000000000);
      send_word(1'b1, 32'hFFFF_FFF6);
      send_word(1'b1, 32'hC465_3600);
      send_word(1'b0, 32'hAAAA_AAAA);
      send_word(1'b1, 32'h5555_5555);

      for (int n = 0; n < RandomItems; n++) begin
         if (n == RandomItems - CalmItems) calm = 1'b1;
         send_word(1'(($urandom_range(0, 1))), pick_value());
      end
      req_valid <= 1'b0;

      // the monitor updates pending at the rising edge, so sample it mid-cycle
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (48) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
